FILE: sv/jht_pkg.sv
`default_nettype none
package jht_pkg;
  localparam int unsigned TwoPiQ16 = 411775;
  localparam int unsigned PiQ16 = 205887;
  localparam int unsigned HalfPiQ16 = 102944;
  localparam int unsigned QuarterPiQ16 = 51472;
  localparam int unsigned SignBiasQ16 = 32'h8000_0000 % TwoPiQ16;
  localparam int unsigned NumStages = 12;

  typedef enum logic [2:0] {
    RegKind    = 3'd0,
    RegAxisX   = 3'd1,
    RegAxisY   = 3'd2,
    RegAxisZ   = 3'd3,
    RegOffsetX = 3'd4,
    RegOffsetY = 3'd5,
    RegOffsetZ = 3'd6,
    RegNone    = 3'd7
  } reg_addr_e;

  typedef struct packed {
    logic        prism;
    logic [18:0] ang;
    logic        neg_s;
    logic        neg_c;
    logic        swap;
    logic [31:0] x;
    logic [31:0] x2;
    logic [31:0] ts;
    logic [31:0] tc;
    logic signed [31:0] q;
    logic [31:0] sn;
    logic [31:0] cs;
  } cell_t;

  function automatic logic [31:0] div_c(input logic [31:0] v, input int unsigned Dv);
    logic [63:0] p;
    logic [31:0] qq;
    begin
      p = 64'(v) * ((64'd1 << 32) / 64'(Dv));
      qq = p[63:32];
      if (64'(qq) * 64'(Dv) > 64'(v)) qq = qq - 32'd1;
      else if (64'(qq + 32'd1) * 64'(Dv) <= 64'(v)) qq = qq + 32'd1;
      return qq;
    end
  endfunction
endpackage
`default_nettype wire

FILE: sv/jht_cell.sv
`default_nettype none
module jht_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  wire jht_pkg::cell_t dat_i,
  output logic                vld_o,
  output jht_pkg::cell_t      dat_o
);
  import jht_pkg::*;
  cell_t d;
  logic vld_q;
  cell_t dat_q;
  logic [63:0] m1;
  logic [63:0] m2;
  logic [31:0] u;
  logic [18:0] rm;
  logic [31:0] one;

  always_comb begin
    d = dat_i;
    one = 32'h4000_0000;
    m1 = '0;
    m2 = '0;
    u = '0;
    rm = '0;
    case (STEP)
      0: begin
        u = dat_i.q ^ 32'h8000_0000;
        d.x = div_c(u, TwoPiQ16);
      end
      1: begin
        u = dat_i.q ^ 32'h8000_0000;
        m1 = 64'(dat_i.x) * 64'(TwoPiQ16);
        rm = 19'(u - m1[31:0]);
        if (rm >= 19'(SignBiasQ16)) d.ang = rm - 19'(SignBiasQ16);
        else d.ang = rm + 19'(TwoPiQ16 - SignBiasQ16);
        if (d.ang >= 19'(PiQ16)) begin
          d.ang = d.ang - 19'(PiQ16);
          d.neg_s = 1'b1;
          d.neg_c = 1'b1;
        end
      end
      2: begin
        if (dat_i.ang > 19'(HalfPiQ16)) begin
          d.ang = 19'(PiQ16) - dat_i.ang;
          d.neg_c = ~dat_i.neg_c;
        end
      end
      3: begin
        if (dat_i.ang > 19'(QuarterPiQ16)) begin
          d.ang = 19'(HalfPiQ16) - dat_i.ang;
          d.swap = 1'b1;
        end
        d.x = 32'(d.ang) << 14;
      end
      4: begin
        m1 = 64'(dat_i.x) * 64'(dat_i.x);
        d.x2 = m1[61:30];
      end
      5: begin
        d.ts = one - div_c(dat_i.x2, 42);
        d.tc = one - div_c(dat_i.x2, 56);
      end
      6: begin
        m1 = 64'(dat_i.x2) * 64'(dat_i.ts);
        m2 = 64'(dat_i.x2) * 64'(dat_i.tc);
        d.ts = m1[61:30];
        d.tc = m2[61:30];
      end
      7: begin
        d.ts = one - div_c(dat_i.ts, 20);
        d.tc = one - div_c(dat_i.tc, 30);
      end
      8: begin
        m1 = 64'(dat_i.x2) * 64'(dat_i.ts);
        m2 = 64'(dat_i.x2) * 64'(dat_i.tc);
        d.ts = m1[61:30];
        d.tc = m2[61:30];
      end
      9: begin
        d.ts = one - div_c(dat_i.ts, 6);
        d.tc = one - div_c(dat_i.tc, 12);
      end
      10: begin
        m1 = 64'(dat_i.x) * 64'(dat_i.ts);
        m2 = 64'(dat_i.x2) * 64'(dat_i.tc);
        d.sn = m1[61:30];
        d.tc = m2[61:30];
      end
      default: begin
        d.cs = one - (dat_i.tc >> 1);
        if (dat_i.swap) begin
          d.sn = d.cs;
          d.cs = dat_i.sn;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;
endmodule
`default_nettype wire

FILE: sv/jht_entry.sv
`default_nettype none
module jht_entry #(
  parameter int unsigned ROT_FRAC_BITS = 14
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic               diag_i,
  input  wire logic               prism_i,
  input  wire logic signed [31:0] s_i,
  input  wire logic signed [31:0] c_i,
  input  wire logic signed [15:0] ka_i,
  input  wire logic signed [15:0] kb_i,
  input  wire logic signed [15:0] ks_i,
  input  wire logic               sneg_i,
  output logic signed [15:0]      r_o
);
  import jht_pkg::*;
  localparam int unsigned AccW = 80;
  localparam logic signed [AccW-1:0] Lim = AccW'(1) << ROT_FRAC_BITS;
  logic signed [31:0] kk_q;
  logic signed [32:0] v_q;
  logic signed [31:0] c_q;
  logic diag_q, prism_q;
  logic signed [AccW-1:0] vkk, acc, rnd, res;
  logic signed [47:0] sk;
  logic signed [47:0] sk_full_q;

  always_comb begin
    sk = 48'(s_i) * 48'(ks_i);
    if (sneg_i) sk = -sk;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kk_q <= 32'(ka_i) * 32'(kb_i);
      v_q <= 33'sh0_4000_0000 - 33'(c_i);
      c_q <= c_i;
      diag_q <= diag_i;
      prism_q <= prism_i;
    end
  end

  logic signed [AccW-1:0] skw;
  always_comb begin
    skw = AccW'(sk_full_q);
    vkk = (AccW'(v_q) * AccW'(kk_q) + (AccW'(1) << (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
    acc = vkk + skw;
    if (diag_q) acc = acc + (AccW'(c_q) <<< ROT_FRAC_BITS);
    rnd = (acc + (AccW'(1) << 29)) >>> 30;
    res = rnd;
    if (res > Lim) res = Lim;
    if (res < -Lim) res = -Lim;
    if (res > AccW'(32767)) res = AccW'(32767);
    if (res < -AccW'(32768)) res = -AccW'(32768);
    if (prism_q) begin
      res = diag_q ? ((Lim > AccW'(32767)) ? AccW'(32767) : Lim) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) sk_full_q <= sk;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_o <= res[15:0];
  end
endmodule
`default_nettype wire

FILE: sv/joint_homogeneous_transform_unit.sv
`default_nettype none
// Joint transform: one joint value in, one 3x4 transform out, one item per cycle.
// A chain of twelve cells reduces the angle and evaluates sine and cosine,
// followed by two entry stages. Whole pipeline stalls only while the output
// is held.
module joint_homogeneous_transform_unit #(
  parameter int unsigned ROT_FRAC_BITS = 14
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] joint_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      r00_o,
  output logic signed [15:0]      r01_o,
  output logic signed [15:0]      r02_o,
  output logic signed [15:0]      r10_o,
  output logic signed [15:0]      r11_o,
  output logic signed [15:0]      r12_o,
  output logic signed [15:0]      r20_o,
  output logic signed [15:0]      r21_o,
  output logic signed [15:0]      r22_o,
  output logic signed [31:0]      trans_x_o,
  output logic signed [31:0]      trans_y_o,
  output logic signed [31:0]      trans_z_o
);
  import jht_pkg::*;
  logic kind_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [31:0] ox_q, oy_q, oz_q;
  reg_addr_e ra;
  logic en;
  logic vld [NumStages+1];
  cell_t dat [NumStages+1];
  cell_t src;
  logic v1_q, v2_q;
  logic signed [31:0] t1x_q, t1y_q, t1z_q;

  assign pready = 1'b1;
  assign ra = (paddr[1:0] == 2'b00) ? reg_addr_e'(paddr[4:2]) : RegNone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
      ax_q <= '0;
      ay_q <= '0;
      az_q <= 16'sd16384;
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ra)
        RegKind:    kind_q <= pwdata[0];
        RegAxisX:   ax_q <= pwdata[15:0];
        RegAxisY:   ay_q <= pwdata[15:0];
        RegAxisZ:   az_q <= pwdata[15:0];
        RegOffsetX: ox_q <= pwdata;
        RegOffsetY: oy_q <= pwdata;
        RegOffsetZ: oz_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      RegKind:    prdata = {31'd0, kind_q};
      RegAxisX:   prdata = {{16{ax_q[15]}}, ax_q};
      RegAxisY:   prdata = {{16{ay_q[15]}}, ay_q};
      RegAxisZ:   prdata = {{16{az_q[15]}}, az_q};
      RegOffsetX: prdata = ox_q;
      RegOffsetY: prdata = oy_q;
      RegOffsetZ: prdata = oz_q;
      default:    prdata = '0;
    endcase
  end

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    src = '0;
    src.q = joint_value_i;
    src.prism = kind_q;
  end

  assign dat[0] = src;
  assign vld[0] = in_valid_i;

  for (genvar g = 0; g < NumStages; g++) begin : g_chain
    jht_cell #(.STEP(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(vld[g]), .dat_i(dat[g]),
      .vld_o(vld[g+1]), .dat_o(dat[g+1])
    );
  end

  logic signed [31:0] s, c;
  always_comb begin
    s = dat[NumStages].neg_s ? -$signed(dat[NumStages].sn) : $signed(dat[NumStages].sn);
    c = dat[NumStages].neg_c ? -$signed(dat[NumStages].cs) : $signed(dat[NumStages].cs);
  end

  logic signed [15:0] ka [9], kb [9], ks [9];
  logic sn [9], dg [9];
  logic signed [15:0] r [9];
  always_comb begin
    ka = '{ax_q, ax_q, ax_q, ax_q, ay_q, ay_q, ax_q, ay_q, az_q};
    kb = '{ax_q, ay_q, az_q, ay_q, ay_q, az_q, az_q, az_q, az_q};
    ks = '{16'sd0, az_q, ay_q, az_q, 16'sd0, ax_q, ay_q, ax_q, 16'sd0};
    sn = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    dg = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  end

  for (genvar e = 0; e < 9; e++) begin : g_ent
    jht_entry #(.ROT_FRAC_BITS(ROT_FRAC_BITS)) u_ent (
      .clk_i, .en_i(en), .diag_i(dg[e]), .prism_i(dat[NumStages].prism),
      .s_i(s), .c_i(c), .ka_i(ka[e]), .kb_i(kb[e]), .ks_i(ks[e]),
      .sneg_i(sn[e]), .r_o(r[e])
    );
  end

  function automatic logic signed [31:0] tr(input logic signed [31:0] o,
                                            input logic signed [31:0] q,
                                            input logic signed [15:0] k,
                                            input logic pr);
    logic signed [63:0] p, t;
    begin
      p = (64'(q) * 64'(k) + (64'sd1 <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
      t = 64'(o) + p;
      if (!pr) t = 64'(o);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= vld[NumStages];
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1x_q <= tr(ox_q, dat[NumStages].q, ax_q, dat[NumStages].prism);
      t1y_q <= tr(oy_q, dat[NumStages].q, ay_q, dat[NumStages].prism);
      t1z_q <= tr(oz_q, dat[NumStages].q, az_q, dat[NumStages].prism);
      trans_x_o <= t1x_q;
      trans_y_o <= t1y_q;
      trans_z_o <= t1z_q;
    end
  end

  assign out_valid_o = v2_q;
  assign r00_o = r[0];
  assign r01_o = r[1];
  assign r02_o = r[2];
  assign r10_o = r[3];
  assign r11_o = r[4];
  assign r12_o = r[5];
  assign r20_o = r[6];
  assign r21_o = r[7];
  assign r22_o = r[8];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(trans_x_o))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("ready low with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !vld[NumStages] |=> !v1_q)
    else $error("spurious result");
endmodule
`default_nettype wire

FILE: sim/joint_homogeneous_transform_unit_tb.sv
`timescale 1ns / 100ps
module joint_homogeneous_transform_unit_tb;
  import jht_pkg::*;

  typedef struct {
    logic signed [15:0] r[9];
    logic signed [31:0] t[3];
  } xform_t;

  typedef struct {
    bit kind;
    int offz;
    int val;
    bit typed;
    int tz;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] joint_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;
  logic signed [31:0] trans_x_o, trans_y_o, trans_z_o;

  joint_homogeneous_transform_unit u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .joint_value_i, .out_valid_o, .out_ready_i,
    .r00_o, .r01_o, .r02_o, .r10_o, .r11_o, .r12_o, .r20_o, .r21_o, .r22_o,
    .trans_x_o, .trans_y_o, .trans_z_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  xform_t pending_xforms[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int prism_sent = 0;
  bit quiet = 1'b0;

  bit kind_q;
  longint ax_q, ay_q, az_q, ox_q, oy_q, oz_q;

  function automatic longint rnd_shr(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  function automatic longint sat_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rot_term(longint c, longint v, longint kk, longint sk, bit diag);
    longint acc;
    acc = rnd_shr(v * kk, 14) + sk;
    if (diag) acc += c * 16384;
    return clamp_unit(rnd_shr(acc, 30));
  endfunction

  function automatic xform_t ident(int tz);
    xform_t e;
    foreach (e.r[i]) e.r[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
    e.t[0] = 0;
    e.t[1] = 0;
    e.t[2] = tz;
    return e;
  endfunction

  function automatic xform_t joint_xform(logic signed [31:0] val);
    xform_t e;
    longint q, a, s, c, v;
    longint unsigned x, x2, t, sn, cs, k;
    bit ns, nc, sw;
    q = val;
    if (kind_q) begin
      e = ident(0);
      e.t[0] = sat_q16(ox_q + rnd_shr(q * ax_q, 14));
      e.t[1] = sat_q16(oy_q + rnd_shr(q * ay_q, 14));
      e.t[2] = sat_q16(oz_q + rnd_shr(q * az_q, 14));
      return e;
    end
    ns = 0;
    nc = 0;
    sw = 0;
    a = q % longint'(TwoPiQ16);
    if (a < 0) a += TwoPiQ16;
    if (a >= PiQ16) begin
      a -= PiQ16;
      ns = ~ns;
      nc = ~nc;
    end
    if (a > HalfPiQ16) begin
      a = PiQ16 - a;
      nc = ~nc;
    end
    if (a > QuarterPiQ16) begin
      a = HalfPiQ16 - a;
      sw = 1;
    end
    x = a << 14;
    x2 = (x * x) >> 30;
    t = (64'd1 << 30) - x2 / 42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    sn = (x * t) >> 30;
    t = (64'd1 << 30) - x2 / 56;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
    cs = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
    if (sw) begin
      k = sn;
      sn = cs;
      cs = k;
    end
    s = ns ? -longint'(sn) : longint'(sn);
    c = nc ? -longint'(cs) : longint'(cs);
    v = (64'sd1 <<< 30) - c;
    e.r[0] = rot_term(c, v, ax_q * ax_q, 0, 1);
    e.r[1] = rot_term(c, v, ax_q * ay_q, -s * az_q, 0);
    e.r[2] = rot_term(c, v, ax_q * az_q, s * ay_q, 0);
    e.r[3] = rot_term(c, v, ax_q * ay_q, s * az_q, 0);
    e.r[4] = rot_term(c, v, ay_q * ay_q, 0, 1);
    e.r[5] = rot_term(c, v, ay_q * az_q, -s * ax_q, 0);
    e.r[6] = rot_term(c, v, ax_q * az_q, -s * ay_q, 0);
    e.r[7] = rot_term(c, v, ay_q * az_q, s * ax_q, 0);
    e.r[8] = rot_term(c, v, az_q * az_q, 0, 1);
    e.t[0] = ox_q;
    e.t[1] = oy_q;
    e.t[2] = oz_q;
    return e;
  endfunction

  task automatic write_reg(reg_addr_e ra, logic [31:0] d);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ra, 2'b00};
    pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (ra)
      RegKind: kind_q = d[0];
      RegAxisX: ax_q = $signed(d[15:0]);
      RegAxisY: ay_q = $signed(d[15:0]);
      RegAxisZ: az_q = $signed(d[15:0]);
      RegOffsetX: ox_q = $signed(d);
      RegOffsetY: oy_q = $signed(d);
      RegOffsetZ: oz_q = $signed(d);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_xforms.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send(logic signed [31:0] val, bit typed, xform_t typed_exp);
    if (!quiet && $urandom_range(99) < 16) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    joint_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_xforms.push_back(typed ? typed_exp : joint_xform(val));
    sent++;
    if (kind_q) prism_sent++;
  endtask

  function automatic logic [31:0] pick_axis();
    case ($urandom_range(5))
      0: return 32'(-16384);
      1: return 32'd0;
      2: return 32'd16384;
      3: return 32'($urandom_range(32768) - 16384);
      default: return 32'($urandom_range(11585) - 5792);
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    int k;
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'(int'($urandom_range(8 * TwoPiQ16)) - 4 * int'(TwoPiQ16));
      2: begin
        k = int'($urandom_range(16)) - 8;
        return 32'(k * int'(QuarterPiQ16) + int'($urandom_range(6)) - 3);
      end
      3: return 32'(int'($urandom_range(131072)) - 65536);
      default: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  row_t rows[18] = '{
    '{0, 0, 0, 1, 0},
    '{0, 0, 32'h7fffffff, 0, 0},
    '{0, 0, 32'h80000000, 0, 0},
    '{0, 0, 411775, 0, 0},
    '{0, 0, -411775, 0, 0},
    '{0, 0, 205887, 0, 0},
    '{0, 0, 205886, 0, 0},
    '{0, 0, 102944, 0, 0},
    '{0, 0, 102943, 0, 0},
    '{0, 0, 51472, 0, 0},
    '{0, 0, 51473, 0, 0},
    '{0, 0, -1, 0, 0},
    '{0, 0, 308831, 0, 0},
    '{1, 0, 32'h7fffffff, 1, 32'h7fffffff},
    '{1, 0, 32'h80000000, 1, 32'h80000000},
    '{1, 32'h7fffffff, 1, 1, 32'h7fffffff},
    '{1, 32'h80000000, -1, 1, 32'h80000000},
    '{1, 5, 0, 1, 5}
  };

  // check each result against the oldest expectation
  always @(posedge clk_i) begin
    xform_t e, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.r = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
      got.t = '{trans_x_o, trans_y_o, trans_z_o};
      if (pending_xforms.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        errors++;
      end else begin
        e = pending_xforms.pop_front();
        checked++;
        foreach (e.r[i])
          if (got.r[i] !== e.r[i]) begin
            $display("%0t: r%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                     e.r[i], got.r[i]);
            errors++;
          end
        foreach (e.t[i])
          if (got.t[i] !== e.t[i]) begin
            $display("%0t: trans[%0d] expected %0d actual %0d", $time, i, e.t[i], got.t[i]);
            errors++;
          end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
  end

  initial begin
    #40_000_000;
    $display("joint_homogeneous_transform_unit_tb NOT OK");
    $finish;
  end

  initial begin
    xform_t dummy;
    int n_phase;
    int n_cfg;
    kind_q = 0;
    ax_q = 0;
    ay_q = 0;
    az_q = 16384;
    ox_q = 0;
    oy_q = 0;
    oz_q = 0;
    n_cfg = 1;
    dummy = ident(0);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind != kind_q || rows[i].offz != oz_q) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        drain();
        write_reg(RegKind, {31'd0, rows[i].kind});
        write_reg(RegOffsetZ, rows[i].offz);
        n_cfg++;
      end
      send(rows[i].val, rows[i].typed, ident(rows[i].tz));
    end

    n_phase = 7;
    for (int p = 0; p < n_phase; p++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      drain();
      write_reg(RegKind, {31'd0, p == 0 ? 1'b0 : (p == 1 ? 1'b1 : 1'($urandom))});
      if (p < 2) begin
        for (int r = RegAxisX; r <= RegAxisZ; r++)
          write_reg(reg_addr_e'(r), p == 0 ? 32'd16384 : 32'(-16384));
        for (int r = RegOffsetX; r <= RegOffsetZ; r++)
          write_reg(reg_addr_e'(r), p == 0 ? 32'h7fffffff : 32'h80000000);
      end else begin
        for (int r = RegAxisX; r <= RegAxisZ; r++) write_reg(reg_addr_e'(r), pick_axis());
        for (int r = RegOffsetX; r <= RegOffsetZ; r++) write_reg(reg_addr_e'(r), pick_offset());
      end
      n_cfg++;
      for (int j = 0; j < 200; j++) begin
        quiet = (p == 3 && j >= 40 && j < 160);
        send(pick_value(), 1'b0, dummy);
      end
      quiet = 1'b0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain();
    $display("sent %0d joint values (%0d prismatic) over %0d register settings",
             sent, prism_sent, n_cfg);
    $display("checked %0d transforms, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("joint_homogeneous_transform_unit_tb OK");
    end else begin
      $display("joint_homogeneous_transform_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
